[sv/ara_pkg.sv]
// Shared types and constants of the address range allocator.
package ara_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int ADDR_BITS     = 64;
  localparam int PORT_W        = 64;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = IDX_W + 1;
  localparam int WCNT_W        = IDX_W + 2;

  typedef logic [ADDR_BITS-1:0] addr_t;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_TAKE    = 2'd1,
    OP_RELEASE = 2'd2,
    OP_RSVD    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FIT   = 2'd1,
    ST_NOT_FREE = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef struct packed {
    logic accept;
    logic scan;
    logic decide;
    logic start_copy;
    logic copy;
    logic tail;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic pass_done;
    logic skip;
    logic is_release;
  } dp_status_t;

endpackage

[sv/ara_ctrl.sv]
// Sequencer of the allocator: scan pass, decision, copy pass, tail push, result.
module ara_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  ara_pkg::dp_status_t st_i,
  output ara_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SCAN   = 6'b000010,
    S_DECIDE = 6'b000100,
    S_COPY   = 6'b001000,
    S_TAIL   = 6'b010000,
    S_DONE   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.accept = 1'b1;
          state_d      = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (st_i.pass_done) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        if (st_i.skip) begin
          state_d = S_DONE;
        end else begin
          cmd_o.start_copy = 1'b1;
          state_d          = S_COPY;
        end
      end
      S_COPY: begin
        cmd_o.copy = 1'b1;
        if (st_i.pass_done) state_d = st_i.is_release ? S_TAIL : S_DONE;
      end
      S_TAIL: begin
        cmd_o.tail = 1'b1;
        state_d    = S_DONE;
      end
      S_DONE: begin
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy = (state_q != S_IDLE);

endmodule

[sv/ara_dpath.sv]
// Range table memory (two banks), scan and copy datapath, result registers.
module ara_dpath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ara_pkg::ctrl_cmd_t            cmd_i,
  output ara_pkg::dp_status_t           st_o,
  input  logic [1:0]                    operation_i,
  input  logic [ara_pkg::PORT_W-1:0]    address_i,
  input  logic [ara_pkg::PORT_W-1:0]    size_i,
  input  logic                          require_free_i,
  output logic                          done_o,
  output logic [ara_pkg::PORT_W-1:0]    granted_address_o,
  output logic [1:0]                    status_o
);

  localparam int AW = ara_pkg::ADDR_BITS;
  localparam int IW = ara_pkg::IDX_W;
  localparam int CW = ara_pkg::CNT_W;
  localparam int WW = ara_pkg::WCNT_W;

  // two banks: read the live one, write the rebuilt table into the other
  logic [2*AW-1:0] mem [2*ara_pkg::TABLE_ENTRIES];
  logic [2*AW-1:0] rdata_q;

  logic              bank_q;
  logic [CW-1:0]     count_q;
  logic [CW-1:0]     ridx_q;
  logic [IW-1:0]     pidx_q;
  logic              v_q, sub_q, placed_q, copying_q;
  logic [WW-1:0]     wcnt_q;

  logic [1:0]        op_q;
  ara_pkg::addr_t    a_q, e_q, size_q;
  logic              rf_q;

  logic              found_q, inside_q;
  logic [IW-1:0]     best_idx_q;
  ara_pkg::addr_t    best_s_q, best_l_q, lo_q, hi_q;

  ara_pkg::addr_t    res_granted_q;
  ara_pkg::status_e  res_status_q;

  ara_pkg::addr_t    in_a, in_sz, in_e;
  ara_pkg::addr_t    s, l, se;
  logic              p0_v, p1_v;
  ara_pkg::addr_t    p0_s, p0_l, p1_s, p1_l;
  logic              stall, rd_en, we;
  ara_pkg::addr_t    w_s, w_l;
  logic              skip;
  ara_pkg::status_e  skip_status;
  ara_pkg::addr_t    skip_granted;
  logic              pass_done;

  assign in_a  = address_i[AW-1:0];
  assign in_sz = size_i[AW-1:0];
  assign in_e  = (in_sz > ('1 - in_a)) ? '1 : in_a + in_sz;

  assign s  = rdata_q[2*AW-1:AW];
  assign l  = rdata_q[AW-1:0];
  assign se = s + l;

  assign pass_done = (ridx_q == count_q) && !v_q;

  // pushes that the current entry causes in the copy pass
  always_comb begin
    p0_v = 1'b0; p0_s = '0; p0_l = '0;
    p1_v = 1'b0; p1_s = '0; p1_l = '0;
    case (op_q)
      ara_pkg::OP_ALLOC: begin
        if (pidx_q == best_idx_q) begin
          if (l != size_q) begin
            p0_v = 1'b1; p0_s = s + size_q; p0_l = l - size_q;
          end
        end else begin
          p0_v = 1'b1; p0_s = s; p0_l = l;
        end
      end
      ara_pkg::OP_TAKE: begin
        if (se <= a_q || s >= e_q) begin
          p0_v = 1'b1; p0_s = s; p0_l = l;
        end else begin
          if (s < a_q) begin
            p0_v = 1'b1; p0_s = s; p0_l = a_q - s;
          end
          if (se > e_q) begin
            p1_v = 1'b1; p1_s = e_q; p1_l = se - e_q;
          end
        end
      end
      ara_pkg::OP_RELEASE: begin
        if (se < a_q) begin
          p1_v = 1'b1; p1_s = s; p1_l = l;
        end else if (s > e_q) begin
          p1_v = 1'b1; p1_s = s; p1_l = l;
          if (!placed_q) begin
            p0_v = 1'b1; p0_s = lo_q; p0_l = hi_q - lo_q;
          end
        end
      end
      default: ;
    endcase
  end

  assign stall = cmd_i.copy && v_q && !sub_q && p0_v && p1_v;
  assign rd_en = (cmd_i.scan || cmd_i.copy) && !stall && (ridx_q < count_q);

  always_comb begin
    we  = 1'b0;
    w_s = p0_s;
    w_l = p0_l;
    if (cmd_i.tail) begin
      we  = !placed_q;
      w_s = lo_q;
      w_l = hi_q - lo_q;
    end else if (cmd_i.copy && v_q) begin
      if (sub_q) begin
        we = 1'b1; w_s = p1_s; w_l = p1_l;
      end else if (p0_v) begin
        we = 1'b1;
      end else if (p1_v) begin
        we = 1'b1; w_s = p1_s; w_l = p1_l;
      end
    end
  end

  always_comb begin
    skip         = 1'b0;
    skip_status  = ara_pkg::ST_OK;
    skip_granted = '0;
    case (op_q)
      ara_pkg::OP_ALLOC: begin
        skip         = !found_q || (size_q == '0);
        skip_status  = found_q ? ara_pkg::ST_OK : ara_pkg::ST_NO_FIT;
        skip_granted = found_q ? best_s_q : '0;
      end
      ara_pkg::OP_TAKE: begin
        skip = (e_q <= a_q) || (rf_q && !inside_q);
        if (e_q > a_q && rf_q && !inside_q) skip_status = ara_pkg::ST_NOT_FREE;
      end
      ara_pkg::OP_RELEASE: skip = (e_q <= a_q);
      default: skip = 1'b1;
    endcase
  end

  assign st_o.pass_done  = pass_done;
  assign st_o.skip       = skip;
  assign st_o.is_release = (op_q == ara_pkg::OP_RELEASE);

  // memory ports
  always_ff @(posedge clk_i) begin
    if (rd_en) rdata_q <= mem[{bank_q, ridx_q[IW-1:0]}];
    if (we && wcnt_q < WW'(ara_pkg::TABLE_ENTRIES)) begin
      mem[{~bank_q, wcnt_q[IW-1:0]}] <= {w_s, w_l};
    end
  end

  // operands and scan results
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q     <= operation_i;
      a_q      <= in_a;
      e_q      <= in_e;
      size_q   <= in_sz;
      rf_q     <= require_free_i;
      lo_q     <= in_a;
      hi_q     <= in_e;
      inside_q <= 1'b0;
      found_q  <= 1'b0;
    end else if (cmd_i.scan && v_q) begin
      if (l >= size_q &&
          (!found_q || l < best_l_q || (l == best_l_q && s < best_s_q))) begin
        found_q    <= 1'b1;
        best_idx_q <= pidx_q;
        best_l_q   <= l;
        best_s_q   <= s;
      end
      if (s <= a_q && e_q <= se) inside_q <= 1'b1;
      if (s <= e_q && se >= a_q) begin
        if (s < lo_q)  lo_q <= s;
        if (se > hi_q) hi_q <= se;
      end
    end
    if (cmd_i.decide) begin
      res_status_q <= skip_status;
      if (skip)                             res_granted_q <= skip_granted;
      else if (op_q == ara_pkg::OP_ALLOC)   res_granted_q <= best_s_q;
      else                                  res_granted_q <= '0;
    end
  end

  // pass control and table commit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q            <= 1'b0;
      count_q           <= '0;
      ridx_q            <= '0;
      pidx_q            <= '0;
      v_q               <= 1'b0;
      sub_q             <= 1'b0;
      placed_q          <= 1'b0;
      copying_q         <= 1'b0;
      wcnt_q            <= '0;
      done_o            <= 1'b0;
      granted_address_o <= '0;
      status_o          <= '0;
    end else begin
      done_o <= cmd_i.finish;
      if (cmd_i.accept || cmd_i.start_copy) begin
        ridx_q <= '0;
        v_q    <= 1'b0;
        sub_q  <= 1'b0;
      end else if (cmd_i.scan || cmd_i.copy) begin
        if (rd_en) begin
          ridx_q <= ridx_q + 1'b1;
          pidx_q <= ridx_q[IW-1:0];
        end
        if (!stall) v_q <= rd_en;
        sub_q <= stall;
      end
      if (cmd_i.accept) copying_q <= 1'b0;
      if (cmd_i.start_copy) begin
        copying_q <= 1'b1;
        wcnt_q    <= '0;
        placed_q  <= 1'b0;
      end else if (we) begin
        wcnt_q <= wcnt_q + 1'b1;
      end
      if (cmd_i.copy && v_q && !sub_q && p0_v && op_q == ara_pkg::OP_RELEASE) begin
        placed_q <= 1'b1;
      end
      if (cmd_i.finish) begin
        if (copying_q && wcnt_q > WW'(ara_pkg::TABLE_ENTRIES)) begin
          status_o          <= ara_pkg::ST_FULL;
          granted_address_o <= '0;
        end else begin
          granted_address_o <= ara_pkg::PORT_W'(res_granted_q);
          status_o          <= res_status_q;
          if (copying_q) begin
            bank_q  <= ~bank_q;
            count_q <= wcnt_q[CW-1:0];
          end
        end
      end
    end
  end

endmodule

[sv/address_range_allocator_core.sv]
// Top level of the best-fit free address range allocator.
//
// The block keeps up to 64 free ranges (start, length) sorted by start and
// runs one command at a time: allocate (best fit, carved from the low end),
// take span (remove a span, splitting ranges) or release span (insert and
// merge with overlapping or touching neighbors). A command transfers at the
// rising edge where start is high and busy is low; busy then stays high until
// the result goes out. Each command produces exactly one result, shown for a
// single cycle with done_o high; the receiver cannot stall it, so capture it
// in that cycle. A command runs as follows: a scan pass reads every entry once
// through the table memory's single read port, then a decision state follows.
// Commands that change the table add a copy pass, whose reads stall for every
// entry that splits in two (take) or for the first entry that follows the
// merged range (release), plus a tail state for release; a done state
// registers the result, which shows in the next cycle. The rebuilt table is
// written into a second memory bank and swapped in only on success, so a
// table-full result (status 3) leaves the table untouched. The table needs
// no clearing after reset.
module address_range_allocator_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 operation_i,
  input  logic [ara_pkg::PORT_W-1:0] address_i,
  input  logic [ara_pkg::PORT_W-1:0] size_i,
  input  logic                       require_free_i,
  output logic                       done_o,
  output logic [ara_pkg::PORT_W-1:0] granted_address_o,
  output logic [1:0]                 status_o
);

  ara_pkg::ctrl_cmd_t  cmd;
  ara_pkg::dp_status_t st;

  // sequence the passes
  ara_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .st_i   (st),
    .cmd_o  (cmd)
  );

  // hold the table, scan it, rebuild it
  ara_dpath u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .st_o              (st),
    .operation_i       (operation_i),
    .address_i         (address_i),
    .size_i            (size_i),
    .require_free_i    (require_free_i),
    .done_o            (done_o),
    .granted_address_o (granted_address_o),
    .status_o          (status_o)
  );

endmodule
